// File: rtl/core/slen_pkg.sv
// Package for the sequential list engine.
// Holds sizes, action and status codes, controller states and the
// command/status structs shared by the controller and the datapath.
`default_nettype none

package slen_pkg;

  // List capacity and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the input and result items.
  localparam int ACT_W  = 3;
  localparam int POS_W  = 8;
  localparam int DATA_W = 32;
  localparam int STS_W  = 2;
  localparam int CMP_W  = POS_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR   = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_LOCATE  = 3'd3,
    ACT_REVERSE = 3'd4,
    ACT_READ    = 3'd5
  } action_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_BAD_POS   = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_MOVE,
    S_INS_FLUSH,
    S_INS_PUT,
    S_DEL_MOVE,
    S_DEL_FLUSH,
    S_LOC_SCAN,
    S_LOC_LAST,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LEN_M1,
    PTR_POS_M1,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    PIPE_OFF,
    PIPE_UP,
    PIPE_DOWN,
    PIPE_SCAN
  } pipe_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_PEND,
    WR_PUT,
    WR_SWAP_LO,
    WR_SWAP_HI
  } wr_op_e;

  typedef enum logic [1:0] {
    LEN_HOLD,
    LEN_CLEAR,
    LEN_INC,
    LEN_DEC
  } len_op_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_FULL,
    RES_BAD_POS,
    RES_NOT_FOUND,
    RES_FOUND,
    RES_ELEM
  } res_op_e;

  typedef enum logic {
    RA_PTR,
    RA_HI
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    ptr_op_e ptr_op;
    logic    hi_load;
    logic    hi_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    pipe_e   pipe;
    wr_op_e  wr_op;
    logic    tmp_load;
    len_op_e len_op;
    res_op_e res_op;
    logic    out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e act;
    logic    full;
    logic    ins_pos_ok;
    logic    ins_at_end;
    logic    acc_pos_ok;
    logic    len_zero;
    logic    len_lt2;
    logic    ptr_at_pos;
    logic    ptr_at_end;
    logic    hit;
    logic    rev_more;
    logic    out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/slen_if.sv
// Handshake interfaces for the input and result channels of the list engine.
// Depends on slen_pkg for the field widths.
`default_nettype none

interface slen_in_if;
  logic                              valid;
  logic                              ready;
  logic [slen_pkg::ACT_W-1:0]        action;
  logic [slen_pkg::POS_W-1:0]        position;
  logic signed [slen_pkg::DATA_W-1:0] value;

  modport source (output valid, output action, output position, output value,
                  input ready);
  modport sink   (input valid, input action, input position, input value,
                  output ready);
endinterface

interface slen_out_if;
  logic                               valid;
  logic                               ready;
  logic [slen_pkg::STS_W-1:0]         status;
  logic [slen_pkg::POS_W-1:0]         found_position;
  logic signed [slen_pkg::DATA_W-1:0] element;
  logic [slen_pkg::POS_W-1:0]         list_length;

  modport source (output valid, output status, output found_position,
                  output element, output list_length, input ready);
  modport sink   (input valid, input status, input found_position,
                  input element, input list_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slen_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module slen_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/slen_datapath.sv
// Datapath of the list engine: item registers, length, walk pointers,
// memory port muxing, result assembly and the output register.
// Depends on slen_pkg; drives the ports of an slen_ram instance.
`default_nettype none

module slen_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire slen_pkg::dp_cmd_t             cmd_i,
  output slen_pkg::dp_sts_t                  sts_o,
  input  wire logic [slen_pkg::ACT_W-1:0]    in_action_i,
  input  wire logic [slen_pkg::POS_W-1:0]    in_position_i,
  input  wire logic signed [slen_pkg::DATA_W-1:0] in_value_i,
  output logic                               ram_we_o,
  output logic [slen_pkg::ADDR_W-1:0]        ram_waddr_o,
  output logic [slen_pkg::DATA_W-1:0]        ram_wdata_o,
  output logic                               ram_re_o,
  output logic [slen_pkg::ADDR_W-1:0]        ram_raddr_o,
  input  wire logic [slen_pkg::DATA_W-1:0]   ram_rdata_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [slen_pkg::STS_W-1:0]         out_status_o,
  output logic [slen_pkg::POS_W-1:0]         out_found_position_o,
  output logic signed [slen_pkg::DATA_W-1:0] out_element_o,
  output logic [slen_pkg::POS_W-1:0]         out_list_length_o
);

  localparam int AW = slen_pkg::ADDR_W;
  localparam int LW = slen_pkg::LEN_W;
  localparam int PW = slen_pkg::POS_W;
  localparam int DW = slen_pkg::DATA_W;
  localparam int CW = slen_pkg::CMP_W;

  // Item registers.
  logic [slen_pkg::ACT_W-1:0] act_q;
  logic [PW-1:0]              pos_q;
  logic [DW-1:0]              val_q;

  // Control registers.
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] hi_q, hi_d;
  logic          pend_q, pend_d;
  logic          cap_q, cap_d;
  logic          out_valid_q, out_valid_d;

  // Payload registers.
  logic [AW-1:0]            wa_q, wa_d;
  logic [DW-1:0]            tmp_q;
  slen_pkg::status_e        wstat_q, wstat_d;
  logic [PW-1:0]            wfound_q, wfound_d;
  logic [DW-1:0]            welem_q, welem_d;
  logic [slen_pkg::STS_W-1:0] out_stat_q;
  logic [PW-1:0]            out_found_q;
  logic [DW-1:0]            out_elem_q;
  logic [PW-1:0]            out_len_q;

  logic [PW-1:0] pos_m1;
  logic [CW-1:0] len_p1;
  logic          out_free;

  assign pos_m1   = pos_q - PW'(1);
  assign len_p1   = CW'(len_q) + CW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  // Status toward the controller.
  always_comb begin
    sts_o.act        = slen_pkg::action_e'(act_q);
    sts_o.full       = len_q >= LW'(slen_pkg::CAPACITY);
    sts_o.ins_pos_ok = (pos_q != '0) && (CW'(pos_q) <= len_p1);
    sts_o.ins_at_end = CW'(pos_q) == len_p1;
    sts_o.acc_pos_ok = (pos_q != '0) && (CW'(pos_q) <= CW'(len_q));
    sts_o.len_zero   = len_q == '0;
    sts_o.len_lt2    = len_q < LW'(2);
    sts_o.ptr_at_pos = PW'(ptr_q) == pos_m1;
    sts_o.ptr_at_end = LW'(ptr_q) == (len_q - LW'(1));
    sts_o.hit        = pend_q && (ram_rdata_i == val_q);
    sts_o.rev_more   = (LW'(hi_q) - LW'(ptr_q)) > LW'(2);
    sts_o.out_free   = out_free;
  end

  // Memory ports.
  always_comb begin
    ram_re_o    = cmd_i.rd_en;
    ram_raddr_o = (cmd_i.rd_sel == slen_pkg::RA_HI) ? hi_q : ptr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wa_q;
    ram_wdata_o = ram_rdata_i;
    case (cmd_i.wr_op)
      slen_pkg::WR_PEND: begin
        ram_we_o = pend_q && !cap_q;
      end
      slen_pkg::WR_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(pos_m1);
        ram_wdata_o = val_q;
      end
      slen_pkg::WR_SWAP_LO: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q;
      end
      slen_pkg::WR_SWAP_HI: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = hi_q;
        ram_wdata_o = tmp_q;
      end
      default: begin
        ram_we_o = 1'b0;
      end
    endcase
  end

  // Next-state logic for pointers, length and the read pipeline.
  always_comb begin
    case (cmd_i.ptr_op)
      slen_pkg::PTR_LEN_M1: ptr_d = AW'(len_q - LW'(1));
      slen_pkg::PTR_POS_M1: ptr_d = AW'(pos_m1);
      slen_pkg::PTR_ZERO:   ptr_d = '0;
      slen_pkg::PTR_INC:    ptr_d = ptr_q + AW'(1);
      slen_pkg::PTR_DEC:    ptr_d = ptr_q - AW'(1);
      default:              ptr_d = ptr_q;
    endcase

    if (cmd_i.hi_load) begin
      hi_d = AW'(len_q - LW'(1));
    end else if (cmd_i.hi_dec) begin
      hi_d = hi_q - AW'(1);
    end else begin
      hi_d = hi_q;
    end

    case (cmd_i.len_op)
      slen_pkg::LEN_CLEAR: len_d = '0;
      slen_pkg::LEN_INC:   len_d = len_q + LW'(1);
      slen_pkg::LEN_DEC:   len_d = len_q - LW'(1);
      default:             len_d = len_q;
    endcase

    // The write address of a pending read is registered with it and used in the cycle after the read.
    pend_d = cmd_i.pipe != slen_pkg::PIPE_OFF;
    cap_d  = (cmd_i.pipe == slen_pkg::PIPE_DOWN) && sts_o.ptr_at_pos;
    case (cmd_i.pipe)
      slen_pkg::PIPE_UP:   wa_d = ptr_q + AW'(1);
      slen_pkg::PIPE_DOWN: wa_d = ptr_q - AW'(1);
      slen_pkg::PIPE_SCAN: wa_d = ptr_q;
      default:             wa_d = wa_q;
    endcase
  end

  // Result assembly.
  always_comb begin
    wstat_d  = wstat_q;
    wfound_d = wfound_q;
    welem_d  = welem_q;
    case (cmd_i.res_op)
      slen_pkg::RES_OK: begin
        wstat_d  = slen_pkg::STS_OK;
        wfound_d = '0;
        welem_d  = '0;
      end
      slen_pkg::RES_FULL: begin
        wstat_d  = slen_pkg::STS_FULL;
        wfound_d = '0;
        welem_d  = '0;
      end
      slen_pkg::RES_BAD_POS: begin
        wstat_d  = slen_pkg::STS_BAD_POS;
        wfound_d = '0;
        welem_d  = '0;
      end
      slen_pkg::RES_NOT_FOUND: begin
        wstat_d  = slen_pkg::STS_NOT_FOUND;
        wfound_d = '0;
        welem_d  = '0;
      end
      slen_pkg::RES_FOUND: begin
        wstat_d  = slen_pkg::STS_OK;
        wfound_d = PW'(wa_q) + PW'(1);
      end
      slen_pkg::RES_ELEM: begin
        welem_d = ram_rdata_i;
      end
      default: begin
        // The first read of a delete walk is the removed element.
        if (pend_q && cap_q) begin
          welem_d = ram_rdata_i;
        end
      end
    endcase
  end

  always_comb begin
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ptr_q       <= '0;
      hi_q        <= '0;
      pend_q      <= 1'b0;
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ptr_q       <= ptr_d;
      hi_q        <= hi_d;
      pend_q      <= pend_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= in_action_i;
      pos_q <= in_position_i;
      val_q <= in_value_i;
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= ram_rdata_i;
    end
    wa_q     <= wa_d;
    wstat_q  <= wstat_d;
    wfound_q <= wfound_d;
    welem_q  <= welem_d;
    if (cmd_i.out_load) begin
      out_stat_q  <= wstat_q;
      out_found_q <= wfound_q;
      out_elem_q  <= welem_q;
      out_len_q   <= PW'(len_q);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_status_o         = out_stat_q;
  assign out_found_position_o = out_found_q;
  assign out_element_o        = out_elem_q;
  assign out_list_length_o    = out_len_q;

endmodule

`default_nettype wire

// File: rtl/core/slen_ctrl.sv
// Controller state machine of the list engine.
// Depends on slen_pkg for the state type and the command/status structs.
`default_nettype none

module slen_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire slen_pkg::dp_sts_t sts_i,
  output slen_pkg::dp_cmd_t      cmd_o
);

  slen_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slen_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      slen_pkg::S_IDLE: begin
        if (in_valid_i) state_d = slen_pkg::S_DECODE;
      end
      slen_pkg::S_DECODE: begin
        case (sts_i.act)
          slen_pkg::ACT_INSERT: begin
            if (sts_i.full || !sts_i.ins_pos_ok) state_d = slen_pkg::S_DONE;
            else if (sts_i.ins_at_end)           state_d = slen_pkg::S_INS_PUT;
            else                                 state_d = slen_pkg::S_INS_MOVE;
          end
          slen_pkg::ACT_DELETE: begin
            state_d = sts_i.acc_pos_ok ? slen_pkg::S_DEL_MOVE : slen_pkg::S_DONE;
          end
          slen_pkg::ACT_LOCATE: begin
            state_d = sts_i.len_zero ? slen_pkg::S_DONE : slen_pkg::S_LOC_SCAN;
          end
          slen_pkg::ACT_REVERSE: begin
            state_d = sts_i.len_lt2 ? slen_pkg::S_DONE : slen_pkg::S_REV_RD_LO;
          end
          slen_pkg::ACT_READ: begin
            state_d = sts_i.acc_pos_ok ? slen_pkg::S_RD_ISSUE : slen_pkg::S_DONE;
          end
          default: begin
            state_d = slen_pkg::S_DONE;
          end
        endcase
      end
      slen_pkg::S_INS_MOVE: begin
        if (sts_i.ptr_at_pos) state_d = slen_pkg::S_INS_FLUSH;
      end
      slen_pkg::S_INS_FLUSH: state_d = slen_pkg::S_INS_PUT;
      slen_pkg::S_INS_PUT:   state_d = slen_pkg::S_DONE;
      slen_pkg::S_DEL_MOVE: begin
        if (sts_i.ptr_at_end) state_d = slen_pkg::S_DEL_FLUSH;
      end
      slen_pkg::S_DEL_FLUSH: state_d = slen_pkg::S_DONE;
      slen_pkg::S_LOC_SCAN: begin
        if (sts_i.hit)             state_d = slen_pkg::S_DONE;
        else if (sts_i.ptr_at_end) state_d = slen_pkg::S_LOC_LAST;
      end
      slen_pkg::S_LOC_LAST:  state_d = slen_pkg::S_DONE;
      slen_pkg::S_REV_RD_LO: state_d = slen_pkg::S_REV_RD_HI;
      slen_pkg::S_REV_RD_HI: state_d = slen_pkg::S_REV_WR_LO;
      slen_pkg::S_REV_WR_LO: state_d = slen_pkg::S_REV_WR_HI;
      slen_pkg::S_REV_WR_HI: begin
        state_d = sts_i.rev_more ? slen_pkg::S_REV_RD_LO : slen_pkg::S_DONE;
      end
      slen_pkg::S_RD_ISSUE: state_d = slen_pkg::S_RD_WAIT;
      slen_pkg::S_RD_WAIT:  state_d = slen_pkg::S_DONE;
      slen_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = slen_pkg::S_IDLE;
      end
      default: state_d = slen_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      slen_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      slen_pkg::S_DECODE: begin
        case (sts_i.act)
          slen_pkg::ACT_CLEAR: begin
            cmd_o.len_op = slen_pkg::LEN_CLEAR;
            cmd_o.res_op = slen_pkg::RES_OK;
          end
          slen_pkg::ACT_INSERT: begin
            if (sts_i.full) begin
              cmd_o.res_op = slen_pkg::RES_FULL;
            end else if (!sts_i.ins_pos_ok) begin
              cmd_o.res_op = slen_pkg::RES_BAD_POS;
            end else begin
              cmd_o.res_op = slen_pkg::RES_OK;
              if (!sts_i.ins_at_end) cmd_o.ptr_op = slen_pkg::PTR_LEN_M1;
            end
          end
          slen_pkg::ACT_DELETE: begin
            if (sts_i.acc_pos_ok) begin
              cmd_o.res_op = slen_pkg::RES_OK;
              cmd_o.ptr_op = slen_pkg::PTR_POS_M1;
            end else begin
              cmd_o.res_op = slen_pkg::RES_BAD_POS;
            end
          end
          slen_pkg::ACT_LOCATE: begin
            if (sts_i.len_zero) begin
              cmd_o.res_op = slen_pkg::RES_NOT_FOUND;
            end else begin
              cmd_o.res_op = slen_pkg::RES_OK;
              cmd_o.ptr_op = slen_pkg::PTR_ZERO;
            end
          end
          slen_pkg::ACT_REVERSE: begin
            cmd_o.res_op = slen_pkg::RES_OK;
            if (!sts_i.len_lt2) begin
              cmd_o.ptr_op  = slen_pkg::PTR_ZERO;
              cmd_o.hi_load = 1'b1;
            end
          end
          slen_pkg::ACT_READ: begin
            if (sts_i.acc_pos_ok) begin
              cmd_o.res_op = slen_pkg::RES_OK;
              cmd_o.ptr_op = slen_pkg::PTR_POS_M1;
            end else begin
              cmd_o.res_op = slen_pkg::RES_BAD_POS;
            end
          end
          default: begin
            cmd_o.res_op = slen_pkg::RES_OK;
          end
        endcase
      end
      slen_pkg::S_INS_MOVE: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.pipe  = slen_pkg::PIPE_UP;
        cmd_o.wr_op = slen_pkg::WR_PEND;
        if (!sts_i.ptr_at_pos) cmd_o.ptr_op = slen_pkg::PTR_DEC;
      end
      slen_pkg::S_INS_FLUSH: begin
        cmd_o.wr_op = slen_pkg::WR_PEND;
      end
      slen_pkg::S_INS_PUT: begin
        cmd_o.wr_op  = slen_pkg::WR_PUT;
        cmd_o.len_op = slen_pkg::LEN_INC;
      end
      slen_pkg::S_DEL_MOVE: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.pipe  = slen_pkg::PIPE_DOWN;
        cmd_o.wr_op = slen_pkg::WR_PEND;
        if (!sts_i.ptr_at_end) cmd_o.ptr_op = slen_pkg::PTR_INC;
      end
      slen_pkg::S_DEL_FLUSH: begin
        cmd_o.wr_op  = slen_pkg::WR_PEND;
        cmd_o.len_op = slen_pkg::LEN_DEC;
      end
      slen_pkg::S_LOC_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.pipe  = slen_pkg::PIPE_SCAN;
        if (sts_i.hit) begin
          cmd_o.res_op = slen_pkg::RES_FOUND;
        end else if (!sts_i.ptr_at_end) begin
          cmd_o.ptr_op = slen_pkg::PTR_INC;
        end
      end
      slen_pkg::S_LOC_LAST: begin
        cmd_o.res_op = sts_i.hit ? slen_pkg::RES_FOUND : slen_pkg::RES_NOT_FOUND;
      end
      slen_pkg::S_REV_RD_LO: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = slen_pkg::RA_PTR;
      end
      slen_pkg::S_REV_RD_HI: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = slen_pkg::RA_HI;
        cmd_o.tmp_load = 1'b1;
      end
      slen_pkg::S_REV_WR_LO: begin
        cmd_o.wr_op = slen_pkg::WR_SWAP_LO;
      end
      slen_pkg::S_REV_WR_HI: begin
        cmd_o.wr_op = slen_pkg::WR_SWAP_HI;
        if (sts_i.rev_more) begin
          cmd_o.ptr_op = slen_pkg::PTR_INC;
          cmd_o.hi_dec = 1'b1;
        end
      end
      slen_pkg::S_RD_ISSUE: begin
        cmd_o.rd_en = 1'b1;
      end
      slen_pkg::S_RD_WAIT: begin
        cmd_o.res_op = slen_pkg::RES_ELEM;
      end
      slen_pkg::S_DONE: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/sequential_list_engine.sv
// The engine works on one item at a time; a walk moves element by element through the
// single memory read port (two reads and two writes per swapped pair for reverse).
// Reset clears the length and all control state but not the element store.
`default_nettype none

// Top level of the sequential list engine. Depends on slen_pkg, the channel
// interfaces, slen_ctrl, slen_datapath and slen_ram.
module sequential_list_engine (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  slen_in_if.sink     in_i,
  slen_out_if.source  out_o
);

  // The controller walks one action at a time; the datapath keeps the list
  // length, the walk pointers and the output register, so a finished result
  // may sit in the output register while the next item is taken and worked on.
  slen_pkg::dp_cmd_t cmd;
  slen_pkg::dp_sts_t sts;

  // Memory port signals between the datapath and the element store.
  logic                          ram_we;
  logic [slen_pkg::ADDR_W-1:0]   ram_waddr;
  logic [slen_pkg::DATA_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [slen_pkg::ADDR_W-1:0]   ram_raddr;
  logic [slen_pkg::DATA_W-1:0]   ram_rdata;

  slen_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slen_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .in_action_i          (in_i.action),
    .in_position_i        (in_i.position),
    .in_value_i           (in_i.value),
    .ram_we_o             (ram_we),
    .ram_waddr_o          (ram_waddr),
    .ram_wdata_o          (ram_wdata),
    .ram_re_o             (ram_re),
    .ram_raddr_o          (ram_raddr),
    .ram_rdata_i          (ram_rdata),
    .out_ready_i          (out_o.ready),
    .out_valid_o          (out_o.valid),
    .out_status_o         (out_o.status),
    .out_found_position_o (out_o.found_position),
    .out_element_o        (out_o.element),
    .out_list_length_o    (out_o.list_length)
  );

  // Element store: one write and one registered read per cycle.
  slen_ram #(
    .WIDTH (slen_pkg::DATA_W),
    .DEPTH (slen_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/slen_checker.sv
// Port-level checks for the sequential list engine, bound to its top level.
// Depends on slen_pkg for the capacity and status codes.
`default_nettype none

module slen_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [slen_pkg::STS_W-1:0]    status_i,
  input wire logic [slen_pkg::POS_W-1:0]    found_position_i,
  input wire logic [slen_pkg::DATA_W-1:0]   element_i,
  input wire logic [slen_pkg::POS_W-1:0]    list_length_i
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(found_position_i) && $stable(element_i) && $stable(list_length_i))
    else $error("result changed while stalled");

  // The length never grows past the capacity.
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(list_length_i) <= 32'(slen_pkg::CAPACITY))
    else $error("list length above capacity");

  // A full report only comes from a list at capacity.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == slen_pkg::STS_FULL) |->
    32'(list_length_i) == 32'(slen_pkg::CAPACITY))
    else $error("full status with room left");

  // A found position lies inside the list and comes with an ok status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (found_position_i != '0) |->
    (status_i == slen_pkg::STS_OK) && (found_position_i <= list_length_i))
    else $error("found position inconsistent");

  // Errors never carry an element or a position.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != slen_pkg::STS_OK) |->
    (element_i == '0) && (found_position_i == '0))
    else $error("error result carries data");

endmodule

bind sequential_list_engine slen_checker u_slen_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .found_position_i (out_o.found_position),
  .element_i        (out_o.element),
  .list_length_i    (out_o.list_length)
);

`default_nettype wire

// File: tb/sequential_list_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sequential list engine: directed and random items,
// predicted by a list model kept in the testbench and checked in arrival order.
// Depends on slen_pkg, the slen_in_if/slen_out_if interfaces and the engine RTL.

module sequential_list_engine_tb;
  import slen_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1525;
  // The longest walk is a reverse of a full list.
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int MAX_REPORTS  = 10;

  // Action codes that the engine must ignore.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } list_item_t;

  typedef struct packed {
    status_e                  status;
    logic [POS_W-1:0]         found;
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         length;
  } list_result_t;

  // Contents and length of the list; element 0 is list position 1.
  typedef struct packed {
    logic [CAPACITY-1:0][DATA_W-1:0] mem;
    logic [POS_W-1:0]                len;
  } list_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  slen_in_if  in_if ();
  slen_out_if out_if ();

  sequential_list_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // The stimulus generator tracks its own copy of the list so that it can aim
  // positions and values at the current contents; the checker keeps another one
  // that advances only when the engine accepts an item.
  list_state_t  gen_state;
  list_state_t  model_state;
  list_item_t   pending_q[$];
  list_result_t expected_q[$];
  int           error_cnt = 0;
  int           cycle_cnt = 0;

  // Applies one action to a list and returns the result the engine must report.
  function automatic list_result_t apply_item(inout list_state_t st, input list_item_t it);
    list_result_t res;
    int len;
    int pos;
    int k;
    logic [DATA_W-1:0] swap;
    res = '0;
    res.status = STS_OK;
    len = int'(st.len);
    pos = int'(it.position);
    case (it.action)
      ACT_CLEAR: begin
        st.len = '0;
      end
      ACT_INSERT: begin
        // A full list is reported before the position is looked at.
        if (len >= CAPACITY) begin
          res.status = STS_FULL;
        end else if (pos < 1 || pos > len + 1) begin
          res.status = STS_BAD_POS;
        end else begin
          for (k = len; k >= pos; k--) st.mem[k] = st.mem[k-1];
          st.mem[pos-1] = it.value;
          st.len = POS_W'(len + 1);
        end
      end
      ACT_DELETE: begin
        if (pos < 1 || pos > len) begin
          res.status = STS_BAD_POS;
        end else begin
          res.element = st.mem[pos-1];
          for (k = pos; k < len; k++) st.mem[k-1] = st.mem[k];
          st.len = POS_W'(len - 1);
        end
      end
      ACT_LOCATE: begin
        res.status = STS_NOT_FOUND;
        for (k = 0; k < len && res.found == 0; k++) begin
          if (st.mem[k] == it.value) begin
            res.found  = POS_W'(k + 1);
            res.status = STS_OK;
          end
        end
      end
      ACT_REVERSE: begin
        for (k = 0; k < len / 2; k++) begin
          swap = st.mem[k];
          st.mem[k] = st.mem[len-1-k];
          st.mem[len-1-k] = swap;
        end
      end
      ACT_READ: begin
        if (pos < 1 || pos > len) res.status = STS_BAD_POS;
        else res.element = st.mem[pos-1];
      end
      default: begin
      end
    endcase
    res.length = st.len;
    return res;
  endfunction

  // Random item aimed at the current list. While growing, inserts dominate so that
  // the list fills up and the full case is reached; while shrinking, deletes do.
  function automatic list_item_t pick_list_item(input list_state_t st, input bit shrinking);
    list_item_t it;
    int len;
    int r;
    int aim;
    int ins_pct;
    int del_pct;
    len = int'(st.len);
    r = $urandom_range(0, 99);
    aim = $urandom_range(0, 99);
    ins_pct = shrinking ? 12 : 50;
    del_pct = shrinking ? 50 : 12;
    it.value = $urandom;
    it.position = POS_W'($urandom_range(0, 255));
    if (r < ins_pct) begin
      it.action = ACT_INSERT;
      if (aim < 88) it.position = POS_W'($urandom_range(1, len + 1));
      // Small values give repeated elements, so locate must pick the first match.
      case ($urandom_range(0, 5))
        0, 1: it.value = $urandom_range(0, 7);
        2: it.value = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        default: ;
      endcase
    end else if (r < ins_pct + del_pct || r < 74) begin
      it.action = (r < ins_pct + del_pct) ? ACT_DELETE : ACT_LOCATE;
      if (it.action == ACT_DELETE && len > 0 && aim < 85)
        it.position = POS_W'($urandom_range(1, len));
      if (it.action == ACT_LOCATE && len > 0 && aim < 60)
        it.value = st.mem[$urandom_range(0, len - 1)];
      else if (it.action == ACT_LOCATE && aim < 75)
        it.value = $urandom_range(0, 7);
    end else if (r < 86) begin
      it.action = ACT_READ;
      if (len > 0 && aim < 85) it.position = POS_W'($urandom_range(1, len));
    end else if (r < 95) begin
      it.action = ACT_REVERSE;
    end else if (r < 96) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    end
    return it;
  endfunction

  // Idle length for either side: mostly none or short, a few long, and now and
  // then a calm stretch in which no idling happens at all.
  function automatic int pick_idle(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    pick_idle = 0;
    if (calm > 0) calm--;
    else if (r < 3) calm = $urandom_range(20, 80);
    else if (r < 55) pick_idle = 0;
    else if (r < 93) pick_idle = $urandom_range(1, 3);
    else pick_idle = $urandom_range(8, 40);
  endfunction

  task automatic add_item(input logic [ACT_W-1:0] action, input int position,
                          input logic signed [DATA_W-1:0] value);
    list_item_t it;
    it.action   = action;
    it.position = POS_W'(position);
    it.value    = value;
    void'(apply_item(gen_state, it));
    pending_q.push_back(it);
  endtask

  // Driver: presents pending items one by one and predicts each accepted one.
  int send_gap = 0;
  int send_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.action   <= '0;
      in_if.position <= '0;
      in_if.value    <= '0;
      send_gap = 0;
    end else begin : drive
      list_item_t it;
      if (in_if.valid && in_if.ready) begin
        it.action   = in_if.action;
        it.position = in_if.position;
        it.value    = in_if.value;
        expected_q.push_back(apply_item(model_state, it));
      end
      if (in_if.valid && !in_if.ready) begin
        // Hold the item until the engine takes it.
      end else if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap--;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        in_if.action   <= it.action;
        in_if.position <= it.position;
        in_if.value    <= it.value;
        in_if.valid    <= 1'b1;
        send_gap = pick_idle(send_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: stalls the result channel at random and checks every result item
  // against the oldest prediction.
  int recv_stall = 0;
  int recv_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin : check
      list_result_t got;
      list_result_t exp;
      if (out_if.valid && out_if.ready) begin
        got.status  = status_e'(out_if.status);
        got.found   = out_if.found_position;
        got.element = out_if.element;
        got.length  = out_if.list_length;
        if (expected_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("%0t: result item with nothing expected: status %0d found %0d "
                     , $realtime, got.status, got.found,
                     "element %0d length %0d", got.element, got.length);
        end else begin
          exp = expected_q.pop_front();
          if (got.status !== exp.status || got.found !== exp.found ||
              got.element !== exp.element || got.length !== exp.length) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS)
              $display("%0t: mismatch: expected status %0d found %0d element %0d length %0d, ",
                       $realtime, exp.status, exp.found, exp.element, exp.length,
                       "got status %0d found %0d element %0d length %0d",
                       got.status, got.found, got.element, got.length);
          end
        end
      end
      if (recv_stall > 0) begin
        out_if.ready <= 1'b0;
        recv_stall--;
      end else begin
        out_if.ready <= 1'b1;
        recv_stall = pick_idle(recv_calm);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main
    list_item_t it;
    bit shrinking;
    int n;
    shrinking = 1'b0;
    gen_state = '0;
    model_state = '0;
    rst_ni = 1'b0;

    // Directed part: empty-list corner cases, position limits, extreme values,
    // duplicates for locate, odd and one-element reverse, ignored action codes.
    add_item(ACT_REVERSE, 0, 0);
    add_item(ACT_LOCATE, 0, 0);
    add_item(ACT_DELETE, 1, 0);
    add_item(ACT_READ, 0, 0);
    add_item(ACT_INSERT, 0, 5);
    add_item(ACT_INSERT, 2, 5);
    add_item(ACT_INSERT, 1, 32'sh7fff_ffff);
    add_item(ACT_REVERSE, 1, -1);
    add_item(ACT_INSERT, 1, 32'sh8000_0000);
    add_item(ACT_INSERT, 3, -1);
    add_item(ACT_INSERT, 2, 0);
    add_item(ACT_INSERT, 5, 0);
    add_item(ACT_LOCATE, 255, 0);
    add_item(ACT_LOCATE, 0, 32'sh1234_5678);
    add_item(ACT_READ, 255, 0);
    add_item(ACT_READ, 5, -1);
    add_item(ACT_REVERSE, 0, 0);
    add_item(ACT_READ, 1, 0);
    add_item(ACT_DELETE, 0, 0);
    add_item(ACT_DELETE, 6, 0);
    add_item(ACT_DELETE, 5, 0);
    add_item(ACT_DELETE, 1, -1);
    add_item(ACT_SPARE_LO, 255, -1);
    add_item(ACT_SPARE_HI, 1, 32'sh7fff_ffff);
    add_item(ACT_REVERSE, 255, 0);
    add_item(ACT_CLEAR, 255, -1);

    // Random part: the list swings between empty and full many times.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (!shrinking && gen_state.len == CAPACITY && $urandom_range(0, 3) == 0)
        shrinking = 1'b1;
      else if (shrinking && gen_state.len == 0)
        shrinking = 1'b0;
      it = pick_list_item(gen_state, shrinking);
      add_item(it.action, int'(it.position), it.value);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_if.valid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
